// ----- sv/assert_macros.svh -----
// Assertion macros used by the tokenizer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check sampled on every rising clock edge outside reset
`define SCT_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// Check of a consequence in the cycle after a condition
`define SCT_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("%m: check failed");

`endif

// ----- sv/sct_pkg.sv -----
// Types, character codes and helper functions of the source character tokenizer
`default_nettype none

package sct_pkg;

    localparam int POS_BITS = 16;
    localparam int VAL_BITS = 31;
    localparam logic [VAL_BITS-1:0] NUM_MAX = {VAL_BITS{1'b1}};

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_OP2   = 4'd1,
        M_SLASH = 4'd2,
        M_LINE  = 4'd3,
        M_BLOCK = 4'd4,
        M_STR   = 4'd5,
        M_BQ    = 4'd6,
        M_CH1   = 4'd7,
        M_CH2   = 4'd8,
        M_NUM   = 4'd9,
        M_ID    = 4'd10,
        M_ENDED = 4'd11
    } lex_mode_t;

    typedef enum logic [2:0] {
        TK_PUNCT  = 3'd0,
        TK_NUMBER = 3'd1,
        TK_STRING = 3'd2,
        TK_IDENT  = 3'd3,
        TK_END    = 3'd4,
        TK_ERROR  = 3'd5
    } token_kind_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_BQUOTE  = 8'h60;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        token_kind_t         kind;
        logic [7:0]          c1;
        logic [7:0]          c2;
        logic [VAL_BITS-1:0] val;
        pos_t                s;
        pos_t                e;
    } token_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [7:0]          c1;
        logic [7:0]          c2;
        logic [VAL_BITS-1:0] val;
        logic [15:0]         s;
        logic [15:0]         e;
        logic                last;
    } out_slot_t;

    function automatic logic [15:0] pos_to_port(input pos_t x);
        logic [31:0] w;
        w = 32'(x);
        return w[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || is_digit(c) || (c == CH_USCORE);
    endfunction

    function automatic logic op_pairs(input logic [7:0] a, input logic [7:0] b);
        logic r;
        r = 1'b0;
        case (a)
            CH_MINUS:              r = (b == CH_GT);
            CH_LT, CH_GT, CH_BANG: r = (b == CH_EQ);
            CH_EQ:                 r = (b == CH_EQ) || (b == CH_GT);
            CH_BAR:                r = (b == CH_BAR);
            CH_AMP:                r = (b == CH_AMP);
            default:               r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic pos_t end_start(input pos_t prev);
        return (prev != '0) ? pos_t'(prev - pos_t'(1)) : '0;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sct_if.sv -----
// Valid/ready channel interfaces for source characters and tokens
`default_nettype none

interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface sct_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [30:0] number_value;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic        last_of_run;

    modport source (output valid, output token_kind, output first_char, output second_char,
                    output number_value, output start_pos, output end_pos,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input first_char, input second_char,
                    input number_value, input start_pos, input end_pos,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/source_char_tokenizer_core.sv -----
// Source character tokenizer: one byte per transfer in, tokens out
`default_nettype none

// Takes one source byte per cycle while the buffer has room; a zero byte
// ends the input and every later byte repeats the end token. Each byte is
// decoded combinationally against the lexer mode register and its zero,
// one or two tokens are loaded into a two-entry result buffer. A byte that
// yields one token (or none) is taken every cycle while the sink keeps up;
// a byte that yields two tokens holds the input until the buffer has
// drained its first token. There is no clearing pass after reset.

module source_char_tokenizer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    sct_in_if.sink    src,
    sct_out_if.source res
);
    import sct_pkg::*;
    `include "assert_macros.svh"

    lex_mode_t           mode_reg, mode_next;
    pos_t                offset_reg, offset_next;
    pos_t                begin_reg, begin_next;
    pos_t                prev_end_reg, prev_end_next;
    logic [VAL_BITS-1:0] accum_reg, accum_next;
    logic [7:0]          pend_reg, pend_next;
    logic                star_reg, star_next;

    logic [1:0]          cnt_reg, cnt_next;
    out_slot_t           slot0_reg, slot0_next;
    out_slot_t           slot1_reg, slot1_next;

    logic [7:0]          ch;
    pos_t                p, p1, pe;
    logic                do_idle;
    logic                a_vld, b_vld;
    token_t              tok_a, tok_b;
    logic [1:0]          n_tok;
    logic [VAL_BITS+3:0] prod;
    logic                accept, pop;

    assign ch     = src.ch;
    assign accept = src.valid && src.ready;
    assign pop    = res.valid && res.ready;
    assign src.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && res.ready);

    function automatic out_slot_t to_slot(input token_t t, input logic last);
        out_slot_t o;
        o.kind = t.kind;
        o.c1   = t.c1;
        o.c2   = t.c2;
        o.val  = t.val;
        o.s    = pos_to_port(t.s);
        o.e    = pos_to_port(t.e);
        o.last = last;
        return o;
    endfunction

    always_comb
    begin
        p    = offset_reg;
        p1   = pos_t'(offset_reg + pos_t'(1));
        prod = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
             + (VAL_BITS+4)'(ch - CH_0);

        mode_next   = mode_reg;
        begin_next  = begin_reg;
        accum_next  = accum_reg;
        pend_next   = pend_reg;
        star_next   = star_reg;
        offset_next = offset_reg;
        do_idle     = 1'b0;
        a_vld       = 1'b0;
        b_vld       = 1'b0;
        tok_a       = '0;
        tok_b       = '0;

        unique case (mode_reg)
            M_ENDED:
            begin
                a_vld      = 1'b1;
                tok_a.kind = TK_END;
                tok_a.s    = end_start(prev_end_reg);
                tok_a.e    = p;
            end
            M_OP2:
            begin
                a_vld    = 1'b1;
                tok_a.c1 = pend_reg;
                tok_a.s  = begin_reg;
                if (op_pairs(pend_reg, ch))
                begin
                    tok_a.kind = TK_PUNCT;
                    tok_a.c2   = ch;
                    tok_a.e    = p1;
                    mode_next  = M_IDLE;
                end
                else
                begin
                    tok_a.kind = ((pend_reg == CH_BAR) || (pend_reg == CH_AMP))
                               ? TK_ERROR : TK_PUNCT;
                    tok_a.e    = p;
                    do_idle    = 1'b1;
                end
            end
            M_SLASH:
            begin
                if (ch == CH_SLASH)
                    mode_next = M_LINE;
                else if (ch == CH_STAR)
                begin
                    mode_next = M_BLOCK;
                    star_next = 1'b0;
                end
                else
                begin
                    a_vld      = 1'b1;
                    tok_a.kind = TK_PUNCT;
                    tok_a.c1   = CH_SLASH;
                    tok_a.s    = begin_reg;
                    tok_a.e    = p;
                    do_idle    = 1'b1;
                end
            end
            M_LINE:
            begin
                if (ch == CH_NUL)
                    do_idle = 1'b1;
                else if (ch == CH_NL)
                    mode_next = M_IDLE;
            end
            M_BLOCK:
            begin
                if (ch == CH_NUL)
                begin
                    star_next = 1'b0;
                    do_idle   = 1'b1;
                end
                else if (star_reg && (ch == CH_SLASH))
                begin
                    star_next = 1'b0;
                    mode_next = M_IDLE;
                end
                else
                    star_next = (ch == CH_STAR);
            end
            M_STR, M_BQ:
            begin
                if (ch == CH_NUL)
                    do_idle = 1'b1;
                else if (ch == ((mode_reg == M_STR) ? CH_DQUOTE : CH_BQUOTE))
                begin
                    a_vld      = 1'b1;
                    tok_a.kind = (mode_reg == M_STR) ? TK_STRING : TK_IDENT;
                    tok_a.s    = begin_reg;
                    tok_a.e    = p1;
                    mode_next  = M_IDLE;
                end
            end
            M_CH1:
            begin
                if (ch == CH_NUL)
                begin
                    a_vld      = 1'b1;
                    tok_a.kind = TK_ERROR;
                    tok_a.s    = begin_reg;
                    tok_a.e    = p;
                    do_idle    = 1'b1;
                end
                else
                begin
                    accum_next = VAL_BITS'(ch);
                    mode_next  = M_CH2;
                end
            end
            M_CH2:
            begin
                a_vld   = 1'b1;
                tok_a.s = begin_reg;
                if (ch == CH_SQUOTE)
                begin
                    tok_a.kind = TK_NUMBER;
                    tok_a.val  = accum_reg;
                    tok_a.e    = p1;
                    mode_next  = M_IDLE;
                end
                else
                begin
                    tok_a.kind = TK_ERROR;
                    tok_a.c1   = ch;
                    tok_a.e    = p;
                    do_idle    = 1'b1;
                end
            end
            M_NUM:
            begin
                if (is_digit(ch))
                    accum_next = (prod > (VAL_BITS+4)'(NUM_MAX)) ? NUM_MAX
                               : prod[VAL_BITS-1:0];
                else
                begin
                    a_vld      = 1'b1;
                    tok_a.kind = TK_NUMBER;
                    tok_a.val  = accum_reg;
                    tok_a.s    = begin_reg;
                    tok_a.e    = p;
                    do_idle    = 1'b1;
                end
            end
            M_ID:
            begin
                if (!is_word(ch))
                begin
                    a_vld      = 1'b1;
                    tok_a.kind = TK_IDENT;
                    tok_a.s    = begin_reg;
                    tok_a.e    = p;
                    do_idle    = 1'b1;
                end
            end
            default:
                do_idle = 1'b1;
        endcase

        // end-token start follows the token just emitted by the same byte
        pe = a_vld ? tok_a.e : prev_end_reg;

        if (do_idle)
        begin
            mode_next = M_IDLE;
            if (ch == CH_NUL)
            begin
                b_vld      = 1'b1;
                tok_b.kind = TK_END;
                tok_b.s    = end_start(pe);
                tok_b.e    = p;
                mode_next  = M_ENDED;
            end
            else
            begin
                unique case (ch) inside
                    CH_SPACE, [CH_TAB:CH_CR]:
                        mode_next = M_IDLE;
                    CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                    CH_COMMA, CH_COLON, CH_HASH, CH_PLUS, CH_STAR, CH_PERCENT:
                    begin
                        b_vld      = 1'b1;
                        tok_b.kind = TK_PUNCT;
                        tok_b.c1   = ch;
                        tok_b.s    = p;
                        tok_b.e    = p1;
                    end
                    CH_MINUS, CH_LT, CH_GT, CH_BANG, CH_EQ, CH_BAR, CH_AMP:
                    begin
                        pend_next  = ch;
                        begin_next = p;
                        mode_next  = M_OP2;
                    end
                    CH_SLASH:
                    begin
                        begin_next = p;
                        mode_next  = M_SLASH;
                    end
                    CH_DQUOTE:
                    begin
                        begin_next = p;
                        mode_next  = M_STR;
                    end
                    CH_BQUOTE:
                    begin
                        begin_next = p;
                        mode_next  = M_BQ;
                    end
                    CH_SQUOTE:
                    begin
                        begin_next = p;
                        mode_next  = M_CH1;
                    end
                    [CH_0:CH_9]:
                    begin
                        accum_next = VAL_BITS'(ch - CH_0);
                        begin_next = p;
                        mode_next  = M_NUM;
                    end
                    [CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_USCORE:
                    begin
                        begin_next = p;
                        mode_next  = M_ID;
                    end
                    default:
                    begin
                        b_vld      = 1'b1;
                        tok_b.kind = TK_ERROR;
                        tok_b.c1   = ch;
                        tok_b.s    = p;
                        tok_b.e    = p1;
                    end
                endcase
            end
        end

        prev_end_next = b_vld ? tok_b.e : pe;

        if ((ch != CH_NUL) && (mode_reg != M_ENDED))
            offset_next = p1;

        n_tok = {1'b0, a_vld} + {1'b0, b_vld};
    end

    // result buffer: slot 0 drives the output
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (accept)
        begin
            cnt_next = n_tok;
            if (a_vld)
            begin
                slot0_next = to_slot(tok_a, !b_vld);
                slot1_next = to_slot(tok_b, 1'b1);
            end
            else
                slot0_next = to_slot(tok_b, 1'b1);
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            offset_reg   <= '0;
            begin_reg    <= '0;
            prev_end_reg <= '0;
            accum_reg    <= '0;
            pend_reg     <= '0;
            star_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                mode_reg     <= mode_next;
                offset_reg   <= offset_next;
                begin_reg    <= begin_next;
                prev_end_reg <= prev_end_next;
                accum_reg    <= accum_next;
                pend_reg     <= pend_next;
                star_reg     <= star_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign res.valid        = (cnt_reg != 2'd0);
    assign res.token_kind   = slot0_reg.kind;
    assign res.first_char   = slot0_reg.c1;
    assign res.second_char  = slot0_reg.c2;
    assign res.number_value = slot0_reg.val;
    assign res.start_pos    = slot0_reg.s;
    assign res.end_pos      = slot0_reg.e;
    assign res.last_of_run  = slot0_reg.last;

    `SCT_ASSERT(a_no_take_when_full, !((cnt_reg == 2'd2) && src.ready))
    `SCT_ASSERT_NEXT(a_pair_order, accept && a_vld && b_vld,
        (cnt_reg == 2'd2) && slot1_reg.last && !slot0_reg.last)
    `SCT_ASSERT_NEXT(a_ended_holds, mode_reg == M_ENDED,
        (mode_reg == M_ENDED) && $stable(offset_reg))
    `SCT_ASSERT_NEXT(a_second_follows, pop && (cnt_reg == 2'd2),
        res.valid && res.last_of_run)

endmodule

`default_nettype wire
